### rtl/point_sphere_slab_crop_assert.svh
// assertion macros of the crop block, used by the pss_ctrl module
// no dependencies; included by pss_ctrl, the one file that carries concurrent checks
`ifndef POINT_SPHERE_SLAB_CROP_ASSERT_SVH
`define POINT_SPHERE_SLAB_CROP_ASSERT_SVH

// property must hold at every rising clock edge outside reset
`define PSS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define PSS_ASSERT_NEVER(label, clk, rst, cond, msg) \
   `PSS_ASSERT(label, clk, rst, !(cond), msg)

`endif

### rtl/pss_pkg.sv
// shared types and constants for the point sphere slab crop block
// no dependencies; imported by every module of the block
package pss_pkg;

   localparam int MAX_POINTS     = 65536;
   localparam int CNT_FIELD_MAX  = 131071;
   localparam int CNT_CAP_INT    = (MAX_POINTS < CNT_FIELD_MAX) ? MAX_POINTS : CNT_FIELD_MAX;
   localparam logic [16:0] CNT_CAP  = 17'(CNT_CAP_INT);
   localparam logic [16:0] SLAB_MIN = 17'd3;

   localparam int LANES = 3;

   // register indexes
   localparam logic [2:0] CSR_MODE          = 3'd0;
   localparam logic [2:0] CSR_FILTER_RAD_SQ = 3'd1;
   localparam logic [2:0] CSR_SUB_RAD_SQ    = 3'd2;
   localparam logic [2:0] CSR_HALF_HEIGHT   = 3'd3;
   localparam logic [2:0] CSR_NORMAL_X      = 3'd4;
   localparam logic [2:0] CSR_NORMAL_Y      = 3'd5;
   localparam logic [2:0] CSR_NORMAL_Z      = 3'd6;
   localparam logic [2:0] CSR_SPHERE_RAD    = 3'd7;

   // mode codes; anything else runs the combined test
   localparam logic [1:0] MODE_FILTER   = 2'd0;
   localparam logic [1:0] MODE_SUBCLOUD = 2'd1;
   localparam logic [1:0] MODE_COMBINED = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic [31:0]        filter_radius_sq;
      logic [31:0]        subcloud_radius_sq;
      logic [15:0]        half_height;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic [14:0]        sphere_radius;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_POINT,
      ST_NORM_RAD,
      ST_SQ_DIFF,
      ST_DOT,
      ST_DECIDE
   } state_type;

   typedef enum logic [1:0] {
      MUL_PP,
      MUL_NR,
      MUL_DD,
      MUL_DN
   } mul_sel_type;

   typedef struct packed {
      logic        capture;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        take_d1;
      logic        take_diff;
      logic        take_d2;
      logic        finish;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

### rtl/pss_csr.sv
// configuration register file of the crop block
// depends on pss_pkg
module pss_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_data,
   output pss_pkg::cfg_type cfg
);
   import pss_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MODE:          cfg_in.mode               = csr_data[1:0];
            CSR_FILTER_RAD_SQ: cfg_in.filter_radius_sq   = csr_data;
            CSR_SUB_RAD_SQ:    cfg_in.subcloud_radius_sq = csr_data;
            CSR_HALF_HEIGHT:   cfg_in.half_height        = csr_data[15:0];
            CSR_NORMAL_X:      cfg_in.normal_x           = csr_data[15:0];
            CSR_NORMAL_Y:      cfg_in.normal_y           = csr_data[15:0];
            CSR_NORMAL_Z:      cfg_in.normal_z           = csr_data[15:0];
            CSR_SPHERE_RAD:    cfg_in.sphere_radius      = csr_data[14:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode               <= MODE_COMBINED;
         cfg_ff.filter_radius_sq   <= '0;
         cfg_ff.subcloud_radius_sq <= '0;
         cfg_ff.half_height        <= '0;
         cfg_ff.normal_x           <= '0;
         cfg_ff.normal_y           <= '0;
         cfg_ff.normal_z           <= -16'sd16384;
         cfg_ff.sphere_radius      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/pss_ctrl.sv
// sequencer for one point: squares, query offset, slab projection, decision
// depends on pss_pkg and point_sphere_slab_crop_assert.svh
`include "point_sphere_slab_crop_assert.svh"

module pss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  pss_pkg::status_type status,
   output pss_pkg::cmd_type    cmd
);
   import pss_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_tvalid) state_in = ST_SQ_POINT;
         ST_SQ_POINT: state_in = ST_NORM_RAD;
         ST_NORM_RAD: state_in = ST_SQ_DIFF;
         ST_SQ_DIFF:  state_in = ST_DOT;
         ST_DOT:      state_in = ST_DECIDE;
         ST_DECIDE:   if (status.out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_SQ_POINT: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_PP;
         end
         ST_NORM_RAD: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_NR;
            cmd.take_d1 = 1'b1;
         end
         ST_SQ_DIFF: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MUL_DD;
            cmd.take_diff = 1'b1;
         end
         ST_DOT: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DN;
            cmd.take_d2 = 1'b1;
         end
         ST_DECIDE: begin
            cmd.finish = status.out_free;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `PSS_ASSERT(a_accept_starts, clock, reset, (req_tvalid && req_tready) |=> (state_ff == ST_SQ_POINT), "accepted point did not start the sequence")
   `PSS_ASSERT_NEVER(a_finish_blocked, clock, reset, cmd.finish && !status.out_free, "result loaded over a waiting result")
   `PSS_ASSERT(a_decide_holds, clock, reset, (state_ff == ST_DECIDE && !status.out_free) |=> (state_ff == ST_DECIDE), "decision dropped while output stalled")
   `PSS_ASSERT(a_finish_idles, clock, reset, cmd.finish |=> (state_ff == ST_IDLE && req_tready), "sequencer not idle after result")

endmodule

### rtl/pss_datapath.sv
// datapath: three multiplier lanes, sphere and slab compares, counters, result register
// depends on pss_pkg; driven by pss_ctrl commands
module pss_datapath (
   input  logic                clock,
   input  logic                reset,
   input  pss_pkg::cfg_type    cfg,
   input  pss_pkg::cmd_type    cmd,
   input  logic [47:0]         req_tdata,
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [55:0]         rsp_tdata,
   output logic                rsp_tlast,
   output pss_pkg::status_type status
);
   import pss_pkg::*;

   logic signed [15:0] pnt_ff [LANES];
   logic               last_ff;
   logic signed [15:0] nrm    [LANES];
   logic signed [31:0] mul_a  [LANES];
   logic signed [31:0] mul_b  [LANES];
   logic signed [63:0] prod_in[LANES];
   logic signed [63:0] prod_ff[LANES];
   logic signed [31:0] diff_in[LANES];
   logic signed [31:0] diff_ff[LANES];
   logic [31:0]        d1_in, d1_ff;
   logic [62:0]        d2_in, d2_ff;
   logic signed [48:0] dot_sum;
   logic [48:0]        dot_abs;
   logic               outside_filter, inside_sub, in_band;
   logic               wide, slab;
   logic [15:0]        index_ff, index_in;
   logic [16:0]        wcnt_ff, wcnt_in, wcnt_new;
   logic [16:0]        scnt_ff, scnt_in, scnt_new;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        out_index_ff;
   logic               out_wide_ff, out_slab_ff, out_last_ff, out_use_ff;
   logic [16:0]        out_wcnt_ff, out_scnt_ff;

   assign nrm[0] = cfg.normal_x;
   assign nrm[1] = cfg.normal_y;
   assign nrm[2] = cfg.normal_z;

   // lane operand select and multiply
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         diff_in[i] = {{2{pnt_ff[i][15]}}, pnt_ff[i], 14'd0} - prod_ff[i][31:0];
         case (cmd.mul_sel)
            MUL_PP: begin
               mul_a[i] = {{16{pnt_ff[i][15]}}, pnt_ff[i]};
               mul_b[i] = {{16{pnt_ff[i][15]}}, pnt_ff[i]};
            end
            MUL_NR: begin
               mul_a[i] = {{16{nrm[i][15]}}, nrm[i]};
               mul_b[i] = {17'd0, cfg.sphere_radius};
            end
            MUL_DD: begin
               mul_a[i] = diff_in[i];
               mul_b[i] = diff_in[i];
            end
            MUL_DN: begin
               mul_a[i] = diff_ff[i];
               mul_b[i] = {{16{nrm[i][15]}}, nrm[i]};
            end
            default: begin
               mul_a[i] = '0;
               mul_b[i] = '0;
            end
         endcase
         prod_in[i] = mul_a[i] * mul_b[i];
      end
   end

   // sums of the lane products
   always_comb begin
      d1_in   = prod_ff[0][31:0] + prod_ff[1][31:0] + prod_ff[2][31:0];
      d2_in   = {1'b0, prod_ff[0][61:0]} + {1'b0, prod_ff[1][61:0]}
              + {1'b0, prod_ff[2][61:0]};
      dot_sum = {{2{prod_ff[0][46]}}, prod_ff[0][46:0]}
              + {{2{prod_ff[1][46]}}, prod_ff[1][46:0]}
              + {{2{prod_ff[2][46]}}, prod_ff[2][46:0]};
      dot_abs = dot_sum[48] ? 49'(-dot_sum) : 49'(dot_sum);
   end

   // decision and counters
   always_comb begin
      outside_filter = d1_ff > cfg.filter_radius_sq;
      inside_sub     = d2_ff <= {3'd0, cfg.subcloud_radius_sq, 28'd0};
      in_band        = dot_abs[47:0] <= {4'd0, cfg.half_height, 28'd0};
      case (cfg.mode)
         MODE_FILTER: begin
            wide = outside_filter;
            slab = 1'b0;
         end
         MODE_SUBCLOUD: begin
            wide = inside_sub;
            slab = inside_sub && in_band;
         end
         default: begin
            wide = outside_filter && inside_sub;
            slab = outside_filter && inside_sub && in_band;
         end
      endcase
      wcnt_new = (wide && wcnt_ff < CNT_CAP) ? wcnt_ff + 17'd1 : wcnt_ff;
      scnt_new = (slab && scnt_ff < CNT_CAP) ? scnt_ff + 17'd1 : scnt_ff;
      index_in = index_ff;
      wcnt_in  = wcnt_ff;
      scnt_in  = scnt_ff;
      if (cmd.finish) begin
         if (last_ff) begin
            index_in = '0;
            wcnt_in  = '0;
            scnt_in  = '0;
         end else begin
            index_in = index_ff + 16'd1;
            wcnt_in  = wcnt_new;
            scnt_in  = scnt_new;
         end
      end
      rsp_valid_in = cmd.finish ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pnt_ff[0] <= req_tdata[15:0];
         pnt_ff[1] <= req_tdata[31:16];
         pnt_ff[2] <= req_tdata[47:32];
         last_ff   <= req_tlast;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.take_diff) begin
         diff_ff <= diff_in;
      end
      if (cmd.take_d1) begin
         d1_ff <= d1_in;
      end
      if (cmd.take_d2) begin
         d2_ff <= d2_in;
      end
      if (cmd.finish) begin
         out_index_ff <= index_ff;
         out_wide_ff  <= wide;
         out_slab_ff  <= slab;
         out_last_ff  <= last_ff;
         out_wcnt_ff  <= wcnt_new;
         out_scnt_ff  <= scnt_new;
         out_use_ff   <= last_ff && (scnt_new < SLAB_MIN);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff     <= '0;
         wcnt_ff      <= '0;
         scnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         index_ff     <= index_in;
         wcnt_ff      <= wcnt_in;
         scnt_ff      <= scnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tlast       = out_last_ff;
   assign rsp_tdata       = {3'd0, out_use_ff, out_scnt_ff, out_wcnt_ff,
                             out_slab_ff, out_wide_ff, out_index_ff};

endmodule

### rtl/point_sphere_slab_crop.sv
// top level of the lidar point sphere and slab crop block
// depends on pss_pkg, pss_csr, pss_ctrl and pss_datapath
//
// One point is worked at a time: it is taken in the idle state, then the three
// lane multipliers (one each for x, y and z, 32 by 32 bits) run four passes
// in sequence (point squares, normal times radius, offset squares, offset
// dot normal) and a final decision state decides, updates the counters and
// loads the result; a new point can be taken in the cycle after the result is
// loaded while that result may still wait in the output register. While a
// result waits, the next point holds in the decision state and the input stays
// closed until the waiting result is taken. Every point gives exactly one
// result. Registers are written through the csr port, which is always ready,
// and should change only while no point is in flight. No clearing pass follows
// reset.
module point_sphere_slab_crop (
   input  logic        clock,
   input  logic        reset,
   // point_x [15:0], point_y [31:16], point_z [47:32]
   input  logic [47:0] req_tdata,
   input  logic        req_tlast,
   input  logic        req_tvalid,
   output logic        req_tready,
   // point_index [15:0], in_wide [16], in_slab [17], wide_count [34:18],
   // slab_count [51:35], use_wide [52], zero [55:53]
   output logic [55:0] rsp_tdata,
   output logic        rsp_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import pss_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   pss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pss_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .status     (status)
   );

endmodule

### tb/sv/point_sphere_slab_crop_tb.sv
// testbench for point_sphere_slab_crop: a directed table of points, then randomized scans
// under many register settings, checked against a behavioral classifier of the crop, or
// against the table for typed rows; depends on pss_pkg and the point_sphere_slab_crop rtl
`timescale 1ns / 1ps

module point_sphere_slab_crop_tb;
   import pss_pkg::*;

   localparam int RAND_ITEMS     = 1050;
   localparam int IDLE_PCT       = 27;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 12;
   localparam int DIR_ROWS       = 20;
   localparam int DIR_SETS       = 5;

   // mode code with no meaning of its own, runs the combined test
   localparam logic [1:0] MODE_SPARE = 2'd3;

   typedef struct packed {
      logic [15:0] point_index;
      logic        in_wide;
      logic        in_slab;
      logic        is_last;
      logic [16:0] wide_count;
      logic [16:0] slab_count;
      logic        use_wide;
   } crop_verdict_type;

   typedef struct packed {
      logic [2:0]         cfg_sel;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic               last;
      logic               typed;
      crop_verdict_type   verdict;
   } point_row_type;

   localparam crop_verdict_type NO_VERDICT = '0;

   // set 0 is the state after reset and is never written
   localparam cfg_type DIR_CFGS [DIR_SETS] = '{
      '{MODE_COMBINED, 32'd0, 32'd0, 16'd0, 16'sd0, 16'sd0, -16'sd16384, 15'd0},
      '{MODE_SUBCLOUD, 32'd0, 32'd1000000, 16'd100, 16'sd0, 16'sd0, 16'sd16384, 15'd1000},
      '{MODE_FILTER, 32'd1000000, 32'd0, 16'd0, 16'sd0, 16'sd0, 16'sd16384, 15'd0},
      '{MODE_SPARE, 32'd0, 32'hFFFFFFFF, 16'hFFFF, 16'sh8000, 16'sh7FFF, 16'sd16384,
        15'h7FFF},
      '{MODE_COMBINED, 32'hFFFFFFFF, 32'd0, 16'd0, 16'sd16384, -16'sd16384, 16'sd0, 15'd0}
   };

   localparam point_row_type DIR_ROWS_TABLE [DIR_ROWS] = '{
      // after reset the query point is the origin, so nothing is kept
      '{3'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1,
        '{16'd0, 1'b0, 1'b0, 1'b0, 17'd0, 17'd0, 1'b0}},
      '{3'd0, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 1'b1,
        '{16'd1, 1'b0, 1'b0, 1'b0, 17'd0, 17'd0, 1'b0}},
      '{3'd0, 16'sd8000, 16'sd8000, 16'sd8000, 1'b0, 1'b1,
        '{16'd2, 1'b0, 1'b0, 1'b0, 17'd0, 17'd0, 1'b0}},
      '{3'd0, 16'sh8000, 16'sd32767, 16'sd0, 1'b1, 1'b1,
        '{16'd3, 1'b0, 1'b0, 1'b1, 17'd0, 17'd0, 1'b1}},
      '{3'd0, 16'sd1, 16'sd0, 16'sd0, 1'b1, 1'b1,
        '{16'd0, 1'b0, 1'b0, 1'b1, 17'd0, 17'd0, 1'b1}},
      // sphere and slab edges around the query point (0, 0, 1000)
      '{3'd1, 16'sd0, 16'sd0, 16'sd1000, 1'b0, 1'b0, NO_VERDICT},
      '{3'd1, 16'sd0, 16'sd0, 16'sd1100, 1'b0, 1'b0, NO_VERDICT},
      '{3'd1, 16'sd0, 16'sd0, 16'sd1101, 1'b0, 1'b0, NO_VERDICT},
      '{3'd1, 16'sd1000, 16'sd0, 16'sd1000, 1'b0, 1'b0, NO_VERDICT},
      '{3'd1, 16'sd1001, 16'sd0, 16'sd1000, 1'b0, 1'b0, NO_VERDICT},
      '{3'd1, 16'sd0, 16'sd0, 16'sd900, 1'b1, 1'b0, NO_VERDICT},
      // filter radius edge
      '{3'd2, 16'sd1000, 16'sd0, 16'sd0, 1'b0, 1'b0, NO_VERDICT},
      '{3'd2, 16'sd1001, 16'sd0, 16'sd0, 1'b0, 1'b0, NO_VERDICT},
      '{3'd2, 16'sd0, -16'sd1000, 16'sd1, 1'b0, 1'b0, NO_VERDICT},
      '{3'd2, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, NO_VERDICT},
      // spare mode, register extremes, normal out of range
      '{3'd3, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, NO_VERDICT},
      '{3'd3, 16'sh8000, 16'sd32767, 16'sd32767, 1'b0, 1'b0, NO_VERDICT},
      '{3'd3, 16'sd32767, 16'sh8000, 16'sh8000, 1'b1, 1'b0, NO_VERDICT},
      // filter radius at its maximum drops everything
      '{3'd4, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 1'b0, NO_VERDICT},
      '{3'd4, 16'sd32767, 16'sd32767, 16'sd32767, 1'b1, 1'b0, NO_VERDICT}
   };

   logic        clock;
   logic        reset;
   logic [47:0] req_tdata;
   logic        req_tlast;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   point_sphere_slab_crop uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // classifier state
   cfg_type     live_cfg;
   logic [15:0] scan_index;
   logic [16:0] wide_total;
   logic [16:0] slab_total;

   crop_verdict_type pending_verdicts [$];
   int fail_count    = 0;
   int req_idle_pct  = IDLE_PCT;
   int rsp_idle_pct  = IDLE_PCT;
   bit hold_pending  = 1'b0;

   // random point generation around the current query point
   int gen_qx, gen_qy, gen_qz, gen_span;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [63:0] abs_mag(input longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic [63:0] sq_mag(input longint v);
      logic [63:0] m;
      m = abs_mag(v);
      return m * m;
   endfunction

   function automatic logic signed [15:0] clamp16(input int v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
   endfunction

   function automatic crop_verdict_type classify_point(input logic signed [15:0] x, y, z,
                                                       input logic last);
      longint px, py, pz, nx, ny, nz, rad, dx, dy, dz, dot;
      logic [63:0] d1, d2;
      logic outside, inner, band, wide, slab;
      crop_verdict_type v;
      px  = x;
      py  = y;
      pz  = z;
      nx  = live_cfg.normal_x;
      ny  = live_cfg.normal_y;
      nz  = live_cfg.normal_z;
      rad = longint'(live_cfg.sphere_radius);
      d1 = sq_mag(px) + sq_mag(py) + sq_mag(pz);
      outside = d1 > 64'(live_cfg.filter_radius_sq);
      // offsets to the query point, scaled by 2^14
      dx = px * 16384 - nx * rad;
      dy = py * 16384 - ny * rad;
      dz = pz * 16384 - nz * rad;
      d2 = sq_mag(dx) + sq_mag(dy) + sq_mag(dz);
      inner = d2 <= (64'(live_cfg.subcloud_radius_sq) << 28);
      dot = dx * nx + dy * ny + dz * nz;
      band = abs_mag(dot) <= (64'(live_cfg.half_height) << 28);
      case (live_cfg.mode)
         MODE_FILTER: begin
            wide = outside;
            slab = 1'b0;
         end
         MODE_SUBCLOUD: begin
            wide = inner;
            slab = inner && band;
         end
         default: begin
            wide = outside && inner;
            slab = wide && band;
         end
      endcase
      if (wide && wide_total < CNT_CAP) wide_total = wide_total + 17'd1;
      if (slab && slab_total < CNT_CAP) slab_total = slab_total + 17'd1;
      v.point_index = scan_index;
      v.in_wide     = wide;
      v.in_slab     = slab;
      v.is_last     = last;
      v.wide_count  = wide_total;
      v.slab_count  = slab_total;
      v.use_wide    = last && (slab_total < SLAB_MIN);
      if (last) begin
         scan_index = '0;
         wide_total = '0;
         slab_total = '0;
      end else begin
         scan_index = scan_index + 16'd1;
      end
      return v;
   endfunction

   function automatic void check_field(input string name, input int unsigned want, got);
      if (want != got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic check_verdict();
      crop_verdict_type e;
      if (pending_verdicts.size() == 0) begin
         $error("result with no expectation waiting, point_index %0d", rsp_tdata[15:0]);
         fail_count++;
      end else begin
         e = pending_verdicts.pop_front();
         check_field("point_index", e.point_index, rsp_tdata[15:0]);
         check_field("in_wide", e.in_wide, rsp_tdata[16]);
         check_field("in_slab", e.in_slab, rsp_tdata[17]);
         check_field("is_last", e.is_last, rsp_tlast);
         check_field("wide_count", e.wide_count, rsp_tdata[34:18]);
         check_field("slab_count", e.slab_count, rsp_tdata[51:35]);
         check_field("use_wide", e.use_wide, rsp_tdata[52]);
      end
   endtask

   task automatic offer_point(input logic signed [15:0] x, y, z, input logic last,
                              input logic typed, input crop_verdict_type typed_v);
      crop_verdict_type v;
      v = classify_point(x, y, z, last);
      pending_verdicts.push_back(typed ? typed_v : v);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < req_idle_pct);
      end
      req_tdata  <= {z, y, x};
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_cfg(input cfg_type c);
      logic [31:0] value;
      logic [2:0]  idx;
      for (int k = 0; k < 8; k++) begin
         idx = 3'(k);
         case (idx)
            CSR_MODE:          value = {30'd0, c.mode};
            CSR_FILTER_RAD_SQ: value = c.filter_radius_sq;
            CSR_SUB_RAD_SQ:    value = c.subcloud_radius_sq;
            CSR_HALF_HEIGHT:   value = {16'd0, c.half_height};
            CSR_NORMAL_X:      value = {16'd0, c.normal_x};
            CSR_NORMAL_Y:      value = {16'd0, c.normal_y};
            CSR_NORMAL_Z:      value = {16'd0, c.normal_z};
            default:           value = {17'd0, c.sphere_radius};
         endcase
         csr_index <= idx;
         csr_data  <= value;
         csr_valid <= 1'b1;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      live_cfg = c;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic make_rand_cfg(output cfg_type c);
      int nsel, sel, nv [3], rad;
      c.mode = 2'($urandom_range(0, 3));
      nsel = $urandom_range(0, 9);
      for (int k = 0; k < 3; k++) begin
         if (nsel < 7) nv[k] = int'($urandom_range(0, 32768)) - 16384;
         else if (nsel < 9) nv[k] = 0;
         else nv[k] = int'($urandom_range(0, 65535)) - 32768;
      end
      if (nsel == 7 || nsel == 8)
         nv[$urandom_range(0, 2)] = ($urandom_range(0, 1) != 0) ? 16384 : -16384;
      c.normal_x = 16'(nv[0]);
      c.normal_y = 16'(nv[1]);
      c.normal_z = 16'(nv[2]);
      sel = $urandom_range(0, 9);
      if (sel == 0) c.sphere_radius = 15'd0;
      else if (sel == 1) c.sphere_radius = 15'h7FFF;
      else c.sphere_radius = 15'($urandom_range(0, 12000));
      gen_qx = nv[0] * int'(c.sphere_radius) / 16384;
      gen_qy = nv[1] * int'(c.sphere_radius) / 16384;
      gen_qz = nv[2] * int'(c.sphere_radius) / 16384;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         c.subcloud_radius_sq = 32'd0;
         gen_span = $urandom_range(1, 3000);
      end else if (sel == 1) begin
         c.subcloud_radius_sq = 32'hFFFFFFFF;
         gen_span = $urandom_range(1, 20000);
      end else begin
         rad = $urandom_range(1, 20000);
         c.subcloud_radius_sq = 32'(rad * rad);
         gen_span = rad + rad / 8 + 1;
      end
      sel = $urandom_range(0, 9);
      if (sel == 0) c.half_height = 16'd0;
      else if (sel == 1) c.half_height = 16'hFFFF;
      else c.half_height = 16'($urandom_range(0, gen_span));
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         c.filter_radius_sq = 32'd0;
      end else if (sel == 1) begin
         c.filter_radius_sq = 32'hFFFFFFFF;
      end else begin
         rad = $urandom_range(0, 20000);
         c.filter_radius_sq = 32'(rad * rad);
      end
   endtask

   task automatic make_rand_point(output logic signed [15:0] x, y, z);
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
         x = 16'($urandom);
         y = 16'($urandom);
         z = 16'($urandom);
      end else if (sel < 25) begin
         x = clamp16(gen_qx);
         y = clamp16(gen_qy);
         z = clamp16(gen_qz);
      end else begin
         x = clamp16(gen_qx + int'($urandom_range(0, 2 * gen_span)) - gen_span);
         y = clamp16(gen_qy + int'($urandom_range(0, 2 * gen_span)) - gen_span);
         z = clamp16(gen_qz + int'($urandom_range(0, 2 * gen_span)) - gen_span);
      end
   endtask

   // receiver: random back-pressure, one long hold-off on request
   initial begin
      int hold_left;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_verdict();
         if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("point_sphere_slab_crop: mismatch");
      $finish;
   end

   initial begin
      logic [2:0] cur_sel;
      logic signed [15:0] x, y, z;
      cfg_type c;
      point_row_type row;
      int rand_items, rand_phase, scans, len;
      reset      = 1'b1;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      req_tvalid = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      live_cfg   = DIR_CFGS[0];
      scan_index = '0;
      wide_total = '0;
      slab_total = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      cur_sel = 3'd0;
      for (int i = 0; i < DIR_ROWS; i++) begin
         row = DIR_ROWS_TABLE[i];
         if (row.cfg_sel != cur_sel) begin
            wait_idle();
            write_cfg(DIR_CFGS[row.cfg_sel]);
            cur_sel = row.cfg_sel;
         end
         offer_point(row.x, row.y, row.z, row.last, row.typed, row.verdict);
      end

      rand_items = 0;
      rand_phase = 0;
      while (rand_items < RAND_ITEMS) begin
         wait_idle();
         make_rand_cfg(c);
         write_cfg(c);
         req_idle_pct = (rand_phase == 0) ? 0 : IDLE_PCT;
         rsp_idle_pct = (rand_phase == 0) ? 0 : IDLE_PCT;
         if (rand_phase == 3) hold_pending = 1'b1;
         scans = (rand_phase == 0) ? 8 : $urandom_range(2, 6);
         repeat (scans) begin
            len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 10) : $urandom_range(11, 60);
            for (int k = 0; k < len; k++) begin
               make_rand_point(x, y, z);
               offer_point(x, y, z, k == len - 1, 1'b0, NO_VERDICT);
               rand_items++;
            end
         end
         rand_phase++;
      end

      wait_idle();
      if (fail_count == 0)
         $display("point_sphere_slab_crop: match");
      else
         $display("point_sphere_slab_crop: mismatch");
      $finish;
   end

endmodule

### point_sphere_slab_crop.f
+incdir+rtl
rtl/pss_pkg.sv
rtl/pss_csr.sv
rtl/pss_ctrl.sv
rtl/pss_datapath.sv
rtl/point_sphere_slab_crop.sv
tb/sv/point_sphere_slab_crop_tb.sv
